// File: rtl/aip_pkg.sv
// Shared types, constants and helper functions for the ASCII integer parser.
// No dependencies; every other file refers to this package by scoped names.

package aip_pkg;

    localparam int MAX_LEN = 4095;

    typedef logic [7:0]  char_t;
    typedef logic [63:0] value_t;
    typedef logic [2:0]  status_t;
    typedef logic [11:0] index_t;
    typedef logic [7:0]  cfg_addr_t;
    typedef logic [7:0]  cfg_data_t;
    typedef logic [5:0]  base_t;

    localparam index_t POS_CAP = 12'((MAX_LEN < 4095) ? MAX_LEN : 4095);

    // characters
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_X_LO  = 8'h78;
    localparam char_t CH_X_UP  = 8'h58;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_A_LO  = 8'h61;
    localparam char_t CH_Z_LO  = 8'h7A;
    localparam char_t CH_A_UP  = 8'h41;
    localparam char_t CH_Z_UP  = 8'h5A;

    localparam base_t NO_DIGIT = 6'h3F;
    localparam base_t BASE_AUTO = 6'd0;
    localparam base_t BASE_8   = 6'd8;
    localparam base_t BASE_10  = 6'd10;
    localparam base_t BASE_16  = 6'd16;
    localparam base_t BASE_MIN = 6'd2;
    localparam base_t BASE_MAX = 6'd35;

    // status codes
    localparam status_t ST_OK             = 3'd0;
    localparam status_t ST_TOO_BIG        = 3'd1;
    localparam status_t ST_NEG_UNSIGNED   = 3'd2;
    localparam status_t ST_TRAIL_CHR_WARN = 3'd3;
    localparam status_t ST_TRAIL_SPC_WARN = 3'd4;
    localparam status_t ST_NO_DIGITS      = 3'd5;
    localparam status_t ST_TRAIL_CHR_ERR  = 3'd6;
    localparam status_t ST_TRAIL_SPC_ERR  = 3'd7;

    // register indexes
    localparam cfg_addr_t CFG_RADIX  = 8'd0;
    localparam cfg_addr_t CFG_SIGNED = 8'd1;
    localparam cfg_addr_t CFG_WIDTH  = 8'd2;
    localparam cfg_addr_t CFG_FULL   = 8'd3;

    // result width codes
    localparam logic [1:0] RW_8  = 2'd0;
    localparam logic [1:0] RW_16 = 2'd1;
    localparam logic [1:0] RW_32 = 2'd2;
    localparam logic [1:0] RW_64 = 2'd3;

    typedef enum logic [3:0] {
        PH_SIGN   = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_TRAIL  = 4'b1000
    } phase_t;

    typedef struct packed {
        base_t      radix;
        logic       signed_mode;
        logic [1:0] result_width;
        logic       full_mode;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        char_t char_code;
        logic  is_end;
    } item_t;

    // parse state as seen at the terminator, prefix already resolved
    typedef struct packed {
        logic   negative;
        value_t acc;
        logic   overflow;
        logic   digit_seen;
        logic   trailing;
        logic   nonspace;
        index_t stop;
    } snap_t;

    typedef struct packed {
        value_t  value;
        status_t status;
        index_t  end_index;
    } result_t;

    function automatic base_t digit_of(input char_t c);
        base_t d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 6'(c - CH_ZERO);
        end
        else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            d = 6'(c - CH_A_LO + 8'd10);
        end
        else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            d = 6'(c - CH_A_UP + 8'd10);
        end
        return d;
    endfunction

    function automatic index_t sat_add(input index_t pos, input logic [1:0] n);
        logic [12:0] sum;
        sum = {1'b0, pos} + {11'd0, n};
        if (sum > {1'b0, POS_CAP}) begin
            return POS_CAP;
        end
        return sum[11:0];
    endfunction

    // previous value too large for one more digit of this base
    function automatic logic shift_hit(input value_t prev, input base_t base);
        logic hit;
        if (base < 6'd4) begin
            hit = prev[63];
        end
        else if (base < 6'd8) begin
            hit = |prev[63:62];
        end
        else if (base < 6'd16) begin
            hit = |prev[63:61];
        end
        else if (base < 6'd32) begin
            hit = |prev[63:60];
        end
        else begin
            hit = |prev[63:59];
        end
        return hit;
    endfunction

endpackage

// File: rtl/aip_char_if.sv
// Character input channel: valid/ready with one string byte and end flag.
// Depends on aip_pkg.

interface aip_char_if;
    logic           valid;
    logic           ready;
    aip_pkg::char_t char_code;
    logic           is_end;

    modport source (output valid, output char_code, output is_end, input ready);
    modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

// File: rtl/aip_result_if.sv
// Result output channel: valid/ready with value, status and end index.
// Depends on aip_pkg.

interface aip_result_if;
    logic             valid;
    logic             ready;
    aip_pkg::value_t  value;
    aip_pkg::status_t status;
    aip_pkg::index_t  end_index;

    modport source (output valid, output value, output status, output end_index,
                    input ready);
    modport sink   (input valid, input value, input status, input end_index,
                    output ready);
endinterface

// File: rtl/aip_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on aip_pkg.

interface aip_cfg_if;
    logic               valid;
    logic               ready;
    aip_pkg::cfg_addr_t index;
    aip_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ascii_integer_parser_core.sv
// Top level of the streaming ASCII integer parser: config bank, input register,
// scanner, terminator logic and result register. Depends on aip_pkg and the
// aip_char_if, aip_result_if and aip_cfg_if interfaces.

// The parser takes one string byte per clock on the chars channel and gives one
// result on the results channel for each terminator; the terminator passes through
// the input register, then the result register, which holds the result.
// The rate is one byte per clock, set by the scanner's per-byte multiply-add of the
// 64-bit accumulator by the base, which is combinational. Ordinary bytes keep
// flowing while a result waits to be taken; only a terminator waits in the input
// register while the previous result is still held. No clearing pass is needed
// after reset. Configuration writes are accepted at any time and should be made
// while no string is in flight.

module ascii_integer_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    aip_cfg_if.sink       cfg,
    aip_char_if.sink      chars,
    aip_result_if.source  results
);

    aip_pkg::cfg_t    regs;
    aip_pkg::item_t   item;
    aip_pkg::snap_t   snap;
    aip_pkg::result_t fin;
    aip_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             take;

    assign out_free = !out_valid_reg || results.ready;

    aip_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    aip_input_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .out_free (out_free),
        .item     (item),
        .take     (take)
    );

    aip_scanner u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .regs  (regs),
        .snap  (snap)
    );

    aip_finish u_fin (
        .snap (snap),
        .regs (regs),
        .res  (fin)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && item.is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item.is_end)
        begin
            result_reg <= fin;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.value     = result_reg.value;
    assign results.status    = result_reg.status;
    assign results.end_index = result_reg.end_index;

    // a taken terminator always yields a result on the next cycle
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.is_end |=> results.valid)
        else $error("terminator taken without a result");

    // a held terminator must back-pressure the input while the output is stalled
    a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.is_end && results.valid && !results.ready |-> !chars.ready)
        else $error("input accepted while a terminator is blocked");

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == aip_pkg::ST_NO_DIGITS |-> results.value == '0)
        else $error("nonzero value with no digits");

    a_index_capped: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.end_index <= aip_pkg::POS_CAP)
        else $error("end index beyond the position cap");

endmodule

// File: rtl/aip_cfg_regs.sv
// Configuration register bank for the parser.
// Depends on aip_pkg and aip_cfg_if.

module aip_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    aip_cfg_if.sink       cfg,
    output aip_pkg::cfg_t regs
);

    aip_pkg::cfg_t regs_reg;
    logic          wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign regs      = regs_reg;

    // unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.radix        <= aip_pkg::BASE_AUTO;
            regs_reg.signed_mode  <= 1'b0;
            regs_reg.result_width <= aip_pkg::RW_64;
            regs_reg.full_mode    <= 1'b0;
        end
        else if (wr)
        begin
            if (cfg.index == aip_pkg::CFG_RADIX)
            begin
                regs_reg.radix <= cfg.data[5:0];
            end
            if (cfg.index == aip_pkg::CFG_SIGNED)
            begin
                regs_reg.signed_mode <= cfg.data[0];
            end
            if (cfg.index == aip_pkg::CFG_WIDTH)
            begin
                regs_reg.result_width <= cfg.data[1:0];
            end
            if (cfg.index == aip_pkg::CFG_FULL)
            begin
                regs_reg.full_mode <= cfg.data[0];
            end
        end
    end

endmodule

// File: rtl/aip_input_stage.sv
// Input register for the character channel; holds one byte until the scanner
// takes it. Depends on aip_pkg and aip_char_if.

module aip_input_stage (
    input  logic           clk,
    input  logic           rst_n,
    aip_char_if.sink       chars,
    input  logic           out_free,
    output aip_pkg::item_t item,
    output logic           take
);

    logic           valid_reg;
    aip_pkg::char_t char_reg;
    logic           end_reg;
    logic           load;

    // a terminator waits here while the previous result is still unclaimed
    assign take        = valid_reg && (!end_reg || out_free);
    assign chars.ready = !valid_reg || take;
    assign load        = chars.valid && chars.ready;

    assign item.valid     = valid_reg;
    assign item.char_code = char_reg;
    assign item.is_end    = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= chars.char_code;
            end_reg  <= chars.is_end;
        end
    end

endmodule

// File: rtl/aip_scanner.sv
// Per-character parse state: sign run, prefix lookahead, digit accumulation
// and trailing classification. Depends on aip_pkg.

module aip_scanner (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  aip_pkg::item_t  item,
    input  aip_pkg::cfg_t   regs,
    output aip_pkg::snap_t  snap
);

    aip_pkg::phase_t phase_reg, phase_next;
    logic            positive_reg, positive_next;
    logic            held_x_reg, held_x_next;
    aip_pkg::base_t  base_reg, base_next;
    aip_pkg::value_t acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic            seen_reg, seen_next;
    aip_pkg::index_t pos_reg, pos_next;
    aip_pkg::index_t stop_reg, stop_next;
    logic            trail_reg, trail_next;
    logic            nonsp_reg, nonsp_next;

    aip_pkg::char_t  c;
    aip_pkg::base_t  d;
    logic            is_space;
    logic            is_x;
    logic            auto_cfg;
    logic            auto_pfx;
    logic            run_digit;
    logic            run_trail;
    aip_pkg::base_t  dp_base;
    aip_pkg::index_t dp_pos;
    logic [69:0]     prod;
    aip_pkg::value_t mac;
    logic            is_digit;
    logic            wrapped;

    assign c = item.char_code;

    always_comb
    begin
        d        = aip_pkg::digit_of(c);
        is_space = (c == aip_pkg::CH_SPACE) || (c == aip_pkg::CH_TAB);
        is_x     = (c == aip_pkg::CH_X_LO) || (c == aip_pkg::CH_X_UP);
        auto_cfg = (regs.radix < aip_pkg::BASE_MIN) || (regs.radix > aip_pkg::BASE_MAX);
        auto_pfx = (base_reg == aip_pkg::BASE_AUTO);

        phase_next    = phase_reg;
        positive_next = positive_reg;
        held_x_next   = held_x_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        seen_next     = seen_reg;
        pos_next      = pos_reg;
        stop_next     = stop_reg;
        trail_next    = trail_reg;
        nonsp_next    = nonsp_reg;

        run_digit = 1'b0;
        run_trail = 1'b0;
        dp_base   = base_reg;
        dp_pos    = pos_reg;

        case (phase_reg)
            aip_pkg::PH_SIGN:
            begin
                if (c == aip_pkg::CH_PLUS)
                begin
                    positive_next = 1'b1;
                    pos_next      = aip_pkg::sat_add(pos_reg, 2'd1);
                end
                else if (c == aip_pkg::CH_MINUS)
                begin
                    positive_next = !positive_reg;
                    pos_next      = aip_pkg::sat_add(pos_reg, 2'd1);
                end
                else if ((auto_cfg || regs.radix == aip_pkg::BASE_16)
                         && c == aip_pkg::CH_ZERO)
                begin
                    // hold the '0' until the next byte settles the prefix
                    base_next   = auto_cfg ? aip_pkg::BASE_AUTO : aip_pkg::BASE_16;
                    held_x_next = 1'b0;
                    phase_next  = aip_pkg::PH_PREFIX;
                end
                else
                begin
                    dp_base   = auto_cfg ? aip_pkg::BASE_10 : regs.radix;
                    run_digit = 1'b1;
                end
            end
            aip_pkg::PH_PREFIX:
            begin
                if (!held_x_reg)
                begin
                    if (is_x)
                    begin
                        held_x_next = 1'b1;
                    end
                    else if (auto_pfx && d < aip_pkg::BASE_8)
                    begin
                        dp_base   = aip_pkg::BASE_8;
                        dp_pos    = aip_pkg::sat_add(pos_reg, 2'd1);
                        run_digit = 1'b1;
                    end
                    else
                    begin
                        // held '0' counts as a digit of the fallback base
                        dp_base   = auto_pfx ? aip_pkg::BASE_10 : aip_pkg::BASE_16;
                        dp_pos    = aip_pkg::sat_add(pos_reg, 2'd1);
                        seen_next = 1'b1;
                        run_digit = 1'b1;
                    end
                end
                else if (d < aip_pkg::BASE_16)
                begin
                    dp_base   = aip_pkg::BASE_16;
                    dp_pos    = aip_pkg::sat_add(pos_reg, 2'd2);
                    run_digit = 1'b1;
                end
                else
                begin
                    // "0x" without a hex digit: the '0' is the number, 'x' trails
                    base_next  = auto_pfx ? aip_pkg::BASE_10 : aip_pkg::BASE_16;
                    seen_next  = 1'b1;
                    stop_next  = aip_pkg::sat_add(pos_reg, 2'd1);
                    phase_next = aip_pkg::PH_TRAIL;
                    trail_next = 1'b1;
                    nonsp_next = 1'b1;
                    pos_next   = aip_pkg::sat_add(pos_reg, 2'd3);
                end
            end
            aip_pkg::PH_DIGITS:
            begin
                run_digit = 1'b1;
            end
            aip_pkg::PH_TRAIL:
            begin
                run_trail = 1'b1;
            end
            default:
            begin
                run_trail = 1'b0;
            end
        endcase

        prod     = {6'd0, acc_reg} * {64'd0, dp_base};
        mac      = prod[63:0] + {58'd0, d};
        is_digit = d < dp_base;
        wrapped  = regs.signed_mode ? ($signed(acc_reg) > $signed(mac)) : (acc_reg > mac);

        if (run_digit)
        begin
            base_next = dp_base;
            if (is_digit)
            begin
                phase_next = aip_pkg::PH_DIGITS;
                acc_next   = mac;
                ovf_next   = ovf_reg || wrapped || aip_pkg::shift_hit(acc_reg, dp_base);
                seen_next  = 1'b1;
                pos_next   = aip_pkg::sat_add(dp_pos, 2'd1);
            end
            else
            begin
                phase_next = aip_pkg::PH_TRAIL;
                stop_next  = dp_pos;
                trail_next = 1'b1;
                nonsp_next = nonsp_reg || !is_space;
                pos_next   = aip_pkg::sat_add(dp_pos, 2'd1);
            end
        end

        if (run_trail)
        begin
            trail_next = 1'b1;
            nonsp_next = nonsp_reg || !is_space;
            pos_next   = aip_pkg::sat_add(pos_reg, 2'd1);
        end
    end

    // terminator view: a pending prefix resolves as '0' (plus a trailing 'x')
    always_comb
    begin
        snap.negative   = !positive_reg;
        snap.acc        = acc_reg;
        snap.overflow   = ovf_reg;
        snap.digit_seen = seen_reg || (phase_reg == aip_pkg::PH_PREFIX);
        snap.trailing   = trail_reg || (phase_reg == aip_pkg::PH_PREFIX && held_x_reg);
        snap.nonspace   = nonsp_reg || (phase_reg == aip_pkg::PH_PREFIX && held_x_reg);
        if (phase_reg == aip_pkg::PH_PREFIX)
        begin
            snap.stop = aip_pkg::sat_add(pos_reg, 2'd1);
        end
        else if (phase_reg == aip_pkg::PH_TRAIL)
        begin
            snap.stop = stop_reg;
        end
        else
        begin
            snap.stop = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= aip_pkg::PH_SIGN;
            positive_reg <= 1'b1;
            held_x_reg   <= 1'b0;
            base_reg     <= aip_pkg::BASE_AUTO;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            pos_reg      <= '0;
            stop_reg     <= '0;
            trail_reg    <= 1'b0;
            nonsp_reg    <= 1'b0;
        end
        else if (take && item.is_end)
        begin
            phase_reg    <= aip_pkg::PH_SIGN;
            positive_reg <= 1'b1;
            held_x_reg   <= 1'b0;
            base_reg     <= aip_pkg::BASE_AUTO;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            pos_reg      <= '0;
            stop_reg     <= '0;
            trail_reg    <= 1'b0;
            nonsp_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            positive_reg <= positive_next;
            held_x_reg   <= held_x_next;
            base_reg     <= base_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            seen_reg     <= seen_next;
            pos_reg      <= pos_next;
            stop_reg     <= stop_next;
            trail_reg    <= trail_next;
            nonsp_reg    <= nonsp_next;
        end
    end

endmodule

// File: rtl/aip_finish.sv
// Terminator logic: sign application, status priority and width narrowing
// with range check. Depends on aip_pkg.

module aip_finish (
    input  aip_pkg::snap_t   snap,
    input  aip_pkg::cfg_t    regs,
    output aip_pkg::result_t res
);

    aip_pkg::value_t  val;
    aip_pkg::status_t st;
    logic             fits;

    always_comb
    begin
        val = snap.negative ? (64'd0 - snap.acc) : snap.acc;
        st  = snap.overflow ? aip_pkg::ST_TOO_BIG : aip_pkg::ST_OK;
        if (snap.negative && !regs.signed_mode && st == aip_pkg::ST_OK)
        begin
            st = aip_pkg::ST_NEG_UNSIGNED;
        end
        if (!snap.digit_seen)
        begin
            st = aip_pkg::ST_NO_DIGITS;
        end
        if (st == aip_pkg::ST_OK && snap.trailing)
        begin
            st = snap.nonspace ? aip_pkg::ST_TRAIL_CHR_WARN : aip_pkg::ST_TRAIL_SPC_WARN;
        end
        if (regs.full_mode && st != aip_pkg::ST_NO_DIGITS && snap.trailing)
        begin
            st = snap.nonspace ? aip_pkg::ST_TRAIL_CHR_ERR : aip_pkg::ST_TRAIL_SPC_ERR;
        end

        // signed: upper bits must all copy the new sign bit
        case (regs.result_width)
            aip_pkg::RW_8:
            begin
                fits = regs.signed_mode ? (val[63:7] == '0 || val[63:7] == '1)
                                        : (val[63:8] == '0);
                res.value = {56'd0, val[7:0]};
            end
            aip_pkg::RW_16:
            begin
                fits = regs.signed_mode ? (val[63:15] == '0 || val[63:15] == '1)
                                        : (val[63:16] == '0);
                res.value = {48'd0, val[15:0]};
            end
            aip_pkg::RW_32:
            begin
                fits = regs.signed_mode ? (val[63:31] == '0 || val[63:31] == '1)
                                        : (val[63:32] == '0);
                res.value = {32'd0, val[31:0]};
            end
            default:
            begin
                fits      = 1'b1;
                res.value = val;
            end
        endcase

        if (st == aip_pkg::ST_OK && !fits)
        begin
            st = aip_pkg::ST_TOO_BIG;
        end
        res.status    = st;
        res.end_index = snap.stop;
    end

endmodule
